// ----- design/bfkd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfkd_pkg
// Shared types and constants of the epoch key duplicate filter: channel
// widths, operation codes, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfkd_pkg;

  localparam int DEFAULT_MAX_ENTRIES = 64;

  localparam int KEY_W      = 62;
  localparam int CAP_W      = 7;
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic scan_done;
    logic hit;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/bfkd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfkd_ctrl
// Controller of the duplicate filter. It takes one item, lets the datapath
// scan the stored keys, and then commits the outcome to the output register.
// ----------------------------------------------------------------------------
module bfkd_ctrl
  import bfkd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire dp_status_t sts,
  output dp_cmd_t         cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.op_clear || sts.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = !rst;
        cmd.load = s_tvalid && !rst;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_FINISH: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/bfkd_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfkd_datapath
// Key memory, scan counter and comparator, fill count, oldest slot pointer,
// capacity register and the output register of the duplicate filter.
// ----------------------------------------------------------------------------
module bfkd_datapath
  import bfkd_pkg::*;
#(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CAP_W-1:0]      cfg_wdata,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic [IN_USER_W-1:0]  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 sts
);

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [KEY_W-1:0] mem [MAX_ENTRIES];

  logic [KEY_W-1:0] key;
  logic             op;
  logic [KEY_W-1:0] rdata;
  logic             rd_vld;
  logic             hit;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cap_eff;
  logic [AW-1:0]    oldest;
  logic             out_acc;
  logic [CAP_W-1:0] out_occ;

  logic             rd_issue;
  logic [CAP_W-1:0] cap_src;
  logic [W-1:0]     cap_w;
  logic [W-1:0]     cap_sel;
  logic             full;
  logic [AW-1:0]    slot;
  logic [CNT_W-1:0] oldest_inc;
  logic [AW-1:0]    oldest_next;
  logic [CNT_W-1:0] count_next;
  logic [W-1:0]     occ_w;

  // Valid entries are exactly the slots below the fill count.
  assign rd_issue = cmd.scan && (idx < count);

  assign cap_src = rst ? CAP_RESET : cfg_wdata;
  assign cap_w   = W'(cap_src);

  always_comb begin
    if (cap_w == '0) begin
      cap_sel = W'(1);
    end else if (cap_w > W'(MAX_ENTRIES)) begin
      cap_sel = W'(MAX_ENTRIES);
    end else begin
      cap_sel = cap_w;
    end
  end

  assign full        = (count >= cap_eff);
  assign slot        = full ? oldest : count[AW-1:0];
  assign oldest_inc  = CNT_W'(oldest) + CNT_W'(1);
  assign oldest_next = (oldest_inc == cap_eff) ? '0 : oldest_inc[AW-1:0];
  assign count_next  = full ? count : count + CNT_W'(1);
  assign occ_w       = W'(count_next);

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rdata <= mem[idx[AW-1:0]];
    end
    if (cmd.commit && (op == OP_OFFER) && !hit) begin
      mem[slot] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= s_tdata[KEY_W-1:0];
      op  <= s_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      hit     <= 1'b0;
      idx     <= '0;
      count   <= '0;
      oldest  <= '0;
      cap_eff <= cap_sel[CNT_W-1:0];
    end else begin
      rd_vld <= rd_issue;
      if (cmd.load) begin
        hit <= 1'b0;
        idx <= '0;
      end else begin
        if (rd_issue) begin
          idx <= idx + CNT_W'(1);
        end
        if (rd_vld && (rdata == key)) begin
          hit <= 1'b1;
        end
      end
      if (cfg_we) begin
        cap_eff <= cap_sel[CNT_W-1:0];
        count   <= '0;
        oldest  <= '0;
      end else if (cmd.commit) begin
        if (op == OP_CLEAR) begin
          count  <= '0;
          oldest <= '0;
        end else if (!hit) begin
          count <= count_next;
          if (full) begin
            oldest <= oldest_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op == OP_CLEAR) begin
        out_acc <= 1'b0;
        out_occ <= '0;
      end else if (hit) begin
        out_acc <= 1'b0;
        out_occ <= occ_w[CAP_W-1:0] - (full ? CAP_W'(0) : CAP_W'(1));
      end else begin
        out_acc <= 1'b1;
        out_occ <= occ_w[CAP_W-1:0];
      end
    end
  end

  assign m_tdata = {out_occ, out_acc};

  assign sts.op_clear  = (op == OP_CLEAR);
  assign sts.scan_done = (idx == count) && !rd_vld;
  assign sts.hit       = hit;
  assign sts.out_free  = !m_tvalid || m_tready;

endmodule

`default_nettype wire

// ----- design/bounded_fifo_key_deduplicator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_fifo_key_deduplicator
// Duplicate filter for observation-epoch keys with first-in first-out
// replacement once the configured capacity is reached.
// ----------------------------------------------------------------------------
// The slave channel carries one operation per transfer: tuser is the
// operation (offer a key or clear the store) and tdata the key. The master
// channel returns one transfer per operation with the accepted flag and the
// occupancy after the operation. Writing the capacity port empties the store.
// An offered key is compared with the stored keys one memory word per cycle;
// a clear ends the scan at once. The next item is taken in the cycle after
// the result is loaded into the output register, so the next operation may
// enter while a result is still waiting. One item is processed at a time.
// A stalled receiver holds the result in the output register; the item behind
// it then waits for the register to free. Reset empties the store, sets the
// capacity to 64 (limited to the depth) and drops any pending result. No
// clearing pass runs: the fill count marks the valid slots.
// ----------------------------------------------------------------------------
module bounded_fifo_key_deduplicator
  import bfkd_pkg::*;
#(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CAP_W-1:0]      cfg_wdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // receiver_id, time_system, gnss_week, ms_of_week, two bits of zero fill.
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // op.
  input  wire logic [IN_USER_W-1:0]  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // accepted, occupancy.
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  bfkd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfkd_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("Committed result not presented on the master channel.");

  a_no_take_during_scan: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && cmd.scan))
    else $error("Slave channel ready while a scan is in progress.");

  a_new_key_accepted: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !sts.op_clear && !sts.hit) |=> m_tdata[0])
    else $error("New key not reported as accepted.");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && sts.op_clear) |=> (m_tdata == '0))
    else $error("Clear did not report an empty store.");

endmodule

`default_nettype wire

// ----- verif/bounded_fifo_key_deduplicator_test.sv -----
// ----------------------------------------------------------------------------
// bounded_fifo_key_deduplicator_test
// Self-checking bench for the epoch key duplicate filter. Offers, duplicate
// offers and clears are streamed in over several capacity settings. An
// internal predictor of the FIFO replacement store works out the accepted
// flag and the occupancy of every transfer, and these are checked against
// the output stream. The sender pauses in bursts and the receiver stalls
// in patterns, including one long hold-off that fills the block.
// ----------------------------------------------------------------------------
module bounded_fifo_key_deduplicator_test;
  import bfkd_pkg::*;

  localparam int DEPTH = DEFAULT_MAX_ENTRIES;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 400;

  localparam int RX_ALWAYS = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_PERIODIC = 2;
  localparam int RX_SPARSE = 3;

  typedef struct packed {
    logic [29:0] ms_of_week;
    logic [15:0] gnss_week;
    logic [7:0]  time_system;
    logic [7:0]  receiver_id;
  } epoch_key_t;

  typedef struct packed {
    logic       accepted;
    logic [6:0] occupancy;
  } dedup_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CAP_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = OP_OFFER;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  epoch_key_t    stored_key [DEPTH];
  bit            slot_used [DEPTH];
  int            oldest_slot;
  int            fill_count;
  logic [6:0]    capacity_reg;
  dedup_result_t pending_results[$];

  int errors = 0;
  int idle_cycles = 0;
  int rx_style = RX_ALWAYS;
  int rx_hold = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;

  bounded_fifo_key_deduplicator uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic void empty_store();
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      stored_key[i] = '0;
    end
    oldest_slot = 0;
    fill_count = 0;
  endfunction

  function automatic dedup_result_t filter_key(logic op, epoch_key_t key);
    dedup_result_t res;
    bit seen;
    int slot;
    int cap;
    cap = (capacity_reg == 0) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg));
    res.accepted = 1'b0;
    if (op == OP_CLEAR) begin
      empty_store();
    end else begin
      seen = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_used[i] && stored_key[i] == key) seen = 1'b1;
      end
      if (!seen) begin
        if (fill_count >= cap) begin
          slot = oldest_slot % cap;
          oldest_slot = (slot + 1) % cap;
        end else begin
          slot = (oldest_slot + fill_count) % cap;
          fill_count++;
        end
        stored_key[slot] = key;
        slot_used[slot] = 1'b1;
        res.accepted = 1'b1;
      end
    end
    res.occupancy = fill_count[6:0];
    return res;
  endfunction

  always @(posedge clk) begin
    dedup_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual accepted=%0b occupancy=%0d",
                   $time, m_tdata[0], m_tdata[7:1]);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (m_tdata[0] !== want.accepted) begin
            errors++;
            $display("%0t: accepted mismatch, expected %0b actual %0b",
                     $time, want.accepted, m_tdata[0]);
          end
          if (m_tdata[7:1] !== want.occupancy) begin
            errors++;
            $display("%0t: occupancy mismatch, expected %0d actual %0d",
                     $time, want.occupancy, m_tdata[7:1]);
          end
        end
      end
      if (s_tvalid && s_tready)
        pending_results.insert(pending_results.size(),
                               filter_key(s_tuser[0], epoch_key_t'(s_tdata[61:0])));
      if (cfg_we) begin
        capacity_reg = cfg_wdata;
        empty_store();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("bounded_fifo_key_deduplicator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready = 1'b0;
        rx_hold--;
      end else begin
        phase++;
        case (rx_style)
          RX_ALWAYS: m_tready = 1'b1;
          RX_RANDOM: m_tready = ($urandom_range(0, 99) < 60);
          RX_PERIODIC: m_tready = (phase % 5) != 0;
          default: m_tready = (phase % 16) < 3;
        endcase
      end
    end
  end

  task automatic send_item(logic op, epoch_key_t key);
    s_tuser = op;
    s_tdata = {2'b00, key};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        s_tvalid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(0, 20);
      end
    end
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(logic [6:0] value);
    wait_drained();
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic epoch_key_t random_key();
    epoch_key_t k;
    k.receiver_id = 8'($urandom);
    k.time_system = 8'($urandom);
    k.gnss_week = 16'($urandom);
    if ($urandom_range(0, 3) == 0) k.ms_of_week = 30'($urandom);
    else k.ms_of_week = 30'($urandom_range(0, 604799999));
    return k;
  endfunction

  task automatic test_key_extremes();
    epoch_key_t zero_key;
    epoch_key_t ones_key;
    epoch_key_t near_key;
    zero_key = '0;
    ones_key = '1;
    near_key = ones_key;
    near_key.time_system = 8'hFE;
    gaps_on = 1'b0;
    rx_style = RX_ALWAYS;
    send_item(OP_OFFER, zero_key);
    send_item(OP_OFFER, ones_key);
    send_item(OP_OFFER, ones_key);
    send_item(OP_OFFER, near_key);
    send_item(OP_OFFER, zero_key);
    send_item(OP_CLEAR, ones_key);
    send_item(OP_OFFER, ones_key);
    send_item(OP_CLEAR, zero_key);
    send_item(OP_CLEAR, zero_key);
  endtask

  task automatic test_capacity_limits();
    epoch_key_t a;
    epoch_key_t b;
    a = random_key();
    b = random_key();
    set_capacity(7'd0);
    send_item(OP_OFFER, a);
    send_item(OP_OFFER, b);
    send_item(OP_OFFER, a);
    send_item(OP_OFFER, a);
    set_capacity(7'd127);
    send_item(OP_OFFER, a);
    send_item(OP_OFFER, b);
    set_capacity(7'd65);
    send_item(OP_OFFER, b);
  endtask

  task automatic test_fifo_eviction();
    epoch_key_t keys [5];
    set_capacity(7'd3);
    for (int i = 0; i < 5; i++) keys[i] = random_key();
    for (int i = 0; i < 5; i++) send_item(OP_OFFER, keys[i]);
    send_item(OP_OFFER, keys[1]);
    send_item(OP_OFFER, keys[4]);
    send_item(OP_OFFER, keys[0]);
  endtask

  task automatic test_output_stall();
    set_capacity(7'd64);
    gaps_on = 1'b0;
    rx_style = RX_ALWAYS;
    @(negedge clk);
    rx_hold = HOLD_OFF_CYCLES;
    for (int i = 0; i < 20; i++) send_item(OP_OFFER, random_key());
    wait_drained();
  endtask

  task automatic test_random_traffic(logic [6:0] cap_value, int count);
    epoch_key_t pool [$];
    int cap;
    int pick;
    cap = (cap_value == 0) ? 1 : ((cap_value > DEPTH) ? DEPTH : int'(cap_value));
    set_capacity(cap_value);
    repeat (cap + cap / 2 + 2) pool.insert(pool.size(), random_key());
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        rx_style = $urandom_range(RX_ALWAYS, RX_SPARSE);
        gaps_on = $urandom_range(0, 3) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) send_item(OP_CLEAR, random_key());
      else if (pick < 13) send_item(OP_OFFER, random_key());
      else send_item(OP_OFFER, pool[$urandom_range(0, pool.size() - 1)]);
    end
  endtask

  initial begin
    empty_store();
    capacity_reg = CAP_RESET;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    test_key_extremes();
    test_capacity_limits();
    test_fifo_eviction();
    test_output_stall();
    test_random_traffic(7'd1, 110);
    test_random_traffic(7'd2, 110);
    test_random_traffic(7'd5, 115);
    test_random_traffic(7'd17, 115);
    test_random_traffic(7'd64, 130);
    test_random_traffic(7'd127, 110);
    test_random_traffic(7'd0, 90);
    test_random_traffic(7'($urandom_range(0, 127)), 130);
    wait_drained();
    repeat (DEPTH + 10) @(negedge clk);
    if (errors == 0) begin
      $display("bounded_fifo_key_deduplicator verification clean");
    end else begin
      $display("bounded_fifo_key_deduplicator verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/bfkd_pkg.sv
design/bfkd_ctrl.sv
design/bfkd_datapath.sv
design/bounded_fifo_key_deduplicator.sv
verif/bounded_fifo_key_deduplicator_test.sv
